FILE: hdl/cenc_pkg.sv
`default_nettype none

package cenc_pkg;

    // Fixed field widths of the register map and the result.
    localparam int POLY_FIELD  = 14;
    localparam int CFG_DATA_W  = 56;
    localparam int CFG_IDX_W   = 3;
    localparam int K_W         = 4;
    localparam int N_W         = 4;
    localparam int INFO_LEN_W  = 16;
    localparam int CODED_W     = 8;
    localparam int STATUS_W    = 2;
    localparam int K_MIN       = 3;
    localparam int N_DEFAULT   = 2;
    localparam int POLY_PER_GROUP = 4;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CONSTRAINT_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUTS_PER_BIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS_GROUP_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS_GROUP_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_TAIL_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INFO_LENGTH       = 3'd5;

    // Register reset values.
    localparam logic [K_W-1:0]        RST_CONSTRAINT_LENGTH = 4'd7;
    localparam logic [N_W-1:0]        RST_OUTPUTS_PER_BIT   = 4'd2;
    localparam logic [CFG_DATA_W-1:0] RST_TAPS_GROUP_LOW    = 56'd1982555;
    localparam logic [CFG_DATA_W-1:0] RST_TAPS_GROUP_HIGH   = 56'd0;
    localparam logic                  RST_ZERO_TAIL_MODE    = 1'b0;
    localparam logic [INFO_LEN_W-1:0] RST_INFO_LENGTH       = 16'd88;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CONFIG   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TAIL_NONZERO = 2'd2;

    // Per-cell control.
    typedef struct packed {
        logic step;   // shift this cycle
        logic clear;  // frame end: drop the held bit
        logic keep;   // cell lies inside the active memory length
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/convolutional_encoder_rate_1_n_core.sv
`default_nettype none

// Rate 1/n feed-forward convolutional encoder.
//
// Input channel (s_valid / s_ready / s_info_bit): one information or tail bit
// per request. Result channel (m_valid / m_ready / m_coded_bits, m_frame_end,
// m_status): exactly one result per input request, in order.
// Configuration: cfg_wr_en / cfg_index / cfg_wr_data, written while idle.
//
// m_valid rises in the cycle after input acceptance. Throughput is one bit
// per clock while the receiver keeps up: the memory is a row of one-bit cells
// that shift each accepted bit and feed an XOR chain per polynomial, so the
// parity of every coded bit is ready in the acceptance cycle and lands in the
// output register. When the receiver stalls, the output register holds its
// result and s_ready falls until the result is taken; s_ready rises again in
// the same cycle m_ready is seen.
// Reset (aresetn low, synchronous) clears the cell row, the frame position
// and the output valid flag, and loads the default configuration.
// A bad polynomial set yields status bad-config with no state change; a
// nonzero tail bit is flagged and encoded as zero.
module convolutional_encoder_rate_1_n_core #(
    parameter int MAX_CONSTRAINT = 14,
    parameter int MAX_OUTPUTS    = 8,
    parameter int FRAME_LEN_BITS = 16
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // configuration write port
    input  wire                                  cfg_wr_en,
    input  wire  [cenc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [cenc_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    // input channel
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire                                  s_info_bit,
    // result channel
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [cenc_pkg::CODED_W-1:0]         m_coded_bits,
    output logic                                 m_frame_end,
    output logic [cenc_pkg::STATUS_W-1:0]        m_status
);
    import cenc_pkg::*;

    localparam int N_CELLS = MAX_CONSTRAINT - 1;
    localparam int LEN_W   = (FRAME_LEN_BITS < INFO_LEN_W) ? FRAME_LEN_BITS : INFO_LEN_W;
    localparam int POS_W   = LEN_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [K_W-1:0]        constraint_length_reg;
    logic [N_W-1:0]        outputs_per_bit_reg;
    logic [CFG_DATA_W-1:0] taps_group_low_reg;
    logic [CFG_DATA_W-1:0] taps_group_high_reg;
    logic                  zero_tail_mode_reg;
    logic [INFO_LEN_W-1:0] info_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            constraint_length_reg <= RST_CONSTRAINT_LENGTH;
            outputs_per_bit_reg   <= RST_OUTPUTS_PER_BIT;
            taps_group_low_reg    <= RST_TAPS_GROUP_LOW;
            taps_group_high_reg   <= RST_TAPS_GROUP_HIGH;
            zero_tail_mode_reg    <= RST_ZERO_TAIL_MODE;
            info_length_reg       <= RST_INFO_LENGTH;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CONSTRAINT_LENGTH: constraint_length_reg <= cfg_wr_data[K_W-1:0];
                CFG_OUTPUTS_PER_BIT:   outputs_per_bit_reg   <= cfg_wr_data[N_W-1:0];
                CFG_TAPS_GROUP_LOW:    taps_group_low_reg    <= cfg_wr_data;
                CFG_TAPS_GROUP_HIGH:   taps_group_high_reg   <= cfg_wr_data;
                CFG_ZERO_TAIL_MODE:    zero_tail_mode_reg    <= cfg_wr_data[0];
                CFG_INFO_LENGTH:       info_length_reg       <= cfg_wr_data[INFO_LEN_W-1:0];
                default: ; // ignore writes to unmapped indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Effective K and n
    // ------------------------------------------------------------------
    logic [K_W-1:0] k_eff;
    logic [N_W-1:0] n_eff;
    logic [POLY_FIELD:0] reg_mask_wide;
    logic [POLY_FIELD-1:0] reg_mask;

    always_comb begin
        // Clamp K into its legal span.
        if (constraint_length_reg < K_W'(K_MIN)) begin
            k_eff = K_W'(K_MIN);
        end else if (constraint_length_reg > K_W'(MAX_CONSTRAINT)) begin
            k_eff = K_W'(MAX_CONSTRAINT);
        end else begin
            k_eff = constraint_length_reg;
        end
        // Fall back to rate 1/2 on an illegal n.
        if (outputs_per_bit_reg < N_W'(N_DEFAULT) || outputs_per_bit_reg > N_W'(MAX_OUTPUTS)) begin
            n_eff = N_W'(N_DEFAULT);
        end else begin
            n_eff = outputs_per_bit_reg;
        end
        reg_mask_wide = ((POLY_FIELD+1)'(1) << k_eff) - (POLY_FIELD+1)'(1);
        reg_mask      = reg_mask_wide[POLY_FIELD-1:0];
    end

    // ------------------------------------------------------------------
    // Polynomials: extract, check and reverse into tap order
    // ------------------------------------------------------------------
    // rev_poly[j][b] taps the bit that is b steps old (b = 0 is the newest).
    logic [POLY_FIELD-1:0] poly     [MAX_OUTPUTS];
    logic [POLY_FIELD-1:0] rev_full [MAX_OUTPUTS];
    logic [POLY_FIELD-1:0] rev_poly [MAX_OUTPUTS];
    logic [MAX_OUTPUTS-1:0] n_mask;
    logic [MAX_OUTPUTS-1:0] poly_bad;
    logic [K_W-1:0]         rev_shift;
    logic                   cfg_bad;

    assign rev_shift = K_W'(POLY_FIELD) - k_eff;

    always_comb begin
        for (int j = 0; j < MAX_OUTPUTS; j++) begin
            if (j < POLY_PER_GROUP) begin
                poly[j] = taps_group_low_reg[POLY_FIELD*(j % POLY_PER_GROUP) +: POLY_FIELD];
            end else begin
                poly[j] = taps_group_high_reg[POLY_FIELD*(j % POLY_PER_GROUP) +: POLY_FIELD];
            end
            for (int b = 0; b < POLY_FIELD; b++) begin
                rev_full[j][b] = poly[j][POLY_FIELD-1-b];
            end
            rev_poly[j] = rev_full[j] >> rev_shift;
            n_mask[j]   = (N_W'(j) < n_eff);
            // Missing top tap or a tap beyond K.
            poly_bad[j] = n_mask[j] &&
                          (!poly[j][k_eff - K_W'(1)] || ((poly[j] & ~reg_mask) != '0));
        end
        cfg_bad = |poly_bad;
    end

    // ------------------------------------------------------------------
    // Frame tracking
    // ------------------------------------------------------------------
    logic [POS_W-1:0] frame_pos_reg;
    logic [POS_W-1:0] frame_pos_next;
    logic [LEN_W-1:0] len_nz;
    logic [POS_W-1:0] last_pos;
    logic             in_tail;
    logic             frame_done;
    logic             enc_bit;
    logic             accept;
    logic             step;

    assign accept = s_valid && s_ready;
    // Hold all state on a bad polynomial set.
    assign step   = accept && !cfg_bad;

    always_comb begin
        len_nz = info_length_reg[LEN_W-1:0];
        if (len_nz == '0) begin
            len_nz = LEN_W'(1);
        end
        last_pos   = POS_W'(len_nz) + POS_W'(k_eff) - POS_W'(2);
        in_tail    = zero_tail_mode_reg && (frame_pos_reg >= POS_W'(len_nz));
        frame_done = zero_tail_mode_reg && (frame_pos_reg >= last_pos);
        // Encode tail bits as zero whatever arrives.
        enc_bit    = s_info_bit && !in_tail;

        frame_pos_next = frame_pos_reg;
        if (step) begin
            if (!zero_tail_mode_reg || frame_done) begin
                frame_pos_next = '0;
            end else begin
                frame_pos_next = frame_pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pos_reg <= '0;
        end else begin
            frame_pos_reg <= frame_pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Cell row: cell m holds the bit that is m+1 steps old
    // ------------------------------------------------------------------
    logic [MAX_OUTPUTS-1:0] par_chain [N_CELLS+1];
    logic                   cell_bit  [N_CELLS];
    cell_ctrl_t             cell_ctrl [N_CELLS];
    logic [MAX_OUTPUTS-1:0] cell_taps [N_CELLS];
    logic [MAX_OUTPUTS-1:0] new_taps;

    always_comb begin
        for (int j = 0; j < MAX_OUTPUTS; j++) begin
            new_taps[j] = rev_poly[j][0];
        end
    end

    // The newest bit starts every parity chain.
    assign par_chain[0] = new_taps & {MAX_OUTPUTS{enc_bit}};

    for (genvar m = 0; m < N_CELLS; m++) begin : g_cell
        always_comb begin
            for (int j = 0; j < MAX_OUTPUTS; j++) begin
                cell_taps[m][j] = rev_poly[j][m+1];
            end
            cell_ctrl[m].step  = step;
            cell_ctrl[m].clear = frame_done;
            // Drop bits beyond the K-1 remembered ones.
            cell_ctrl[m].keep  = (K_W'(m) < (k_eff - K_W'(1)));
        end

        if (m == 0) begin : g_head
            cenc_cell #(.N_OUT(MAX_OUTPUTS)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (cell_ctrl[m]),
                .bit_in  (enc_bit),
                .taps    (cell_taps[m]),
                .par_in  (par_chain[m]),
                .par_out (par_chain[m+1]),
                .bit_out (cell_bit[m])
            );
        end else begin : g_body
            cenc_cell #(.N_OUT(MAX_OUTPUTS)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (cell_ctrl[m]),
                .bit_in  (cell_bit[m-1]),
                .taps    (cell_taps[m]),
                .par_in  (par_chain[m]),
                .par_out (par_chain[m+1]),
                .bit_out (cell_bit[m])
            );
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [CODED_W-1:0]     m_coded_bits_reg;
    logic                   m_frame_end_reg;
    logic [STATUS_W-1:0]    m_status_reg;
    logic [CODED_W-1:0]     coded_next;
    logic                   frame_end_next;
    logic [STATUS_W-1:0]    status_next;

    // Take a new request whenever the output register is empty or draining.
    assign s_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_bad) begin
            coded_next     = '0;
            frame_end_next = 1'b0;
            status_next    = STATUS_BAD_CONFIG;
        end else begin
            coded_next     = CODED_W'(par_chain[N_CELLS] & n_mask);
            frame_end_next = frame_done;
            status_next    = (in_tail && s_info_bit) ? STATUS_TAIL_NONZERO : STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload needs no reset: it is only seen under m_valid.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_coded_bits_reg <= coded_next;
            m_frame_end_reg  <= frame_end_next;
            m_status_reg     <= status_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_coded_bits = m_coded_bits_reg;
    assign m_frame_end  = m_frame_end_reg;
    assign m_status     = m_status_reg;

endmodule

`default_nettype wire

FILE: hdl/cenc_cell.sv
`default_nettype none

module cenc_cell #(
    parameter int N_OUT = 8
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire cenc_pkg::cell_ctrl_t ctrl,
    input  wire                     bit_in,
    input  wire  [N_OUT-1:0]        taps,
    input  wire  [N_OUT-1:0]        par_in,
    output logic [N_OUT-1:0]        par_out,
    output logic                    bit_out
);
    import cenc_pkg::*;

    logic bit_reg;
    logic bit_next;

    always_comb begin
        bit_next = bit_reg;
        if (ctrl.step) begin
            bit_next = (ctrl.keep && !ctrl.clear) ? bit_in : 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= 1'b0;
        end else begin
            bit_reg <= bit_next;
        end
    end

    // Fold this cell's tapped bit into every running parity.
    assign par_out = par_in ^ (taps & {N_OUT{bit_reg}});
    assign bit_out = bit_reg;

endmodule

`default_nettype wire

FILE: hdl/cenc_checker.sv
`default_nettype none

module cenc_checker (
    input wire                              aclk,
    input wire                              aresetn,
    input wire                              s_valid,
    input wire                              s_ready,
    input wire                              m_valid,
    input wire                              m_ready,
    input wire [cenc_pkg::CODED_W-1:0]      m_coded_bits,
    input wire                              m_frame_end,
    input wire [cenc_pkg::STATUS_W-1:0]     m_status
);
    import cenc_pkg::*;

    // Every accepted request yields a result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("no result after accepted request");

    // An empty output stage never blocks the input.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // A bad configuration result carries no code and no frame end.
    a_bad_cfg_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_BAD_CONFIG) |-> (m_coded_bits == '0 && !m_frame_end))
        else $error("bad configuration result carries data");

    // A stalled result stays put.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_coded_bits) && $stable(m_status)))
        else $error("stalled result changed");

endmodule

bind convolutional_encoder_rate_1_n_core cenc_checker u_cenc_checker (.*);

`default_nettype wire

FILE: tb/sv/cenc_result_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both channels of the encoder, keeps a
// shadow of the registers and the encoder memory, and checks every result.
module cenc_result_checker (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_wr_en,
    input  wire [cenc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [cenc_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire                             s_valid,
    input  wire                             s_ready,
    input  wire                             s_info_bit,
    input  wire                             m_valid,
    input  wire                             m_ready,
    input  wire [cenc_pkg::CODED_W-1:0]     m_coded_bits,
    input  wire                             m_frame_end,
    input  wire [cenc_pkg::STATUS_W-1:0]    m_status,
    output int                              mismatches,
    output int                              outstanding,
    output int                              bits_checked,
    output int                              frame_ends,
    output int                              tail_flags,
    output int                              bad_configs
);
    import cenc_pkg::*;

    typedef struct packed {
        logic [CODED_W-1:0]  coded;
        logic                frame_end;
        logic [STATUS_W-1:0] status;
    } coded_result_t;

    // shadow registers
    logic [K_W-1:0]        k_reg;
    logic [N_W-1:0]        n_reg;
    logic [CFG_DATA_W-1:0] taps_lo;
    logic [CFG_DATA_W-1:0] taps_hi;
    logic                  zero_tail;
    logic [INFO_LEN_W-1:0] info_len;

    // encoder state
    logic [12:0] shift_mem;
    logic [16:0] frame_pos;

    coded_result_t expected_q[$];
    coded_result_t want;
    coded_result_t fresh;
    int            errors;
    int            checked;
    int            ends_seen;
    int            tails_seen;
    int            bads_seen;

    function automatic int poly_at(int j);
        logic [CFG_DATA_W-1:0] group;
        group = (j < POLY_PER_GROUP) ? taps_lo : taps_hi;
        return int'(group[POLY_FIELD*(j % POLY_PER_GROUP) +: POLY_FIELD]);
    endfunction

    // Encode one bit and advance the shadow memory and frame position.
    function automatic coded_result_t encode_bit(logic bit_in);
        coded_result_t r;
        int  k, n, len, last, pos, mem, full, pv, reg_mask, mem_mask, j, i;
        logic din, par, bad;
        r = '0;
        din = bit_in;
        k = int'(k_reg);
        if (k < K_MIN) k = K_MIN;
        if (k > 14) k = 14;
        n = int'(n_reg);
        if (n < 2 || n > 8) n = N_DEFAULT;
        reg_mask = (1 << k) - 1;
        mem_mask = (1 << (k - 1)) - 1;

        bad = 1'b0;
        for (j = 0; j < n; j++) begin
            pv = poly_at(j);
            if (((pv >> (k - 1)) & 1) == 0 || (pv & ~reg_mask) != 0) bad = 1'b1;
        end
        if (bad) begin
            r.status = STATUS_BAD_CONFIG;
            return r;
        end

        r.status = STATUS_OK;
        len = int'(info_len);
        if (len == 0) len = 1;
        last = len + k - 2;
        pos = int'(frame_pos);
        if (zero_tail && pos >= len) begin
            if (din) r.status = STATUS_TAIL_NONZERO;
            din = 1'b0;
        end

        mem  = int'(shift_mem) & mem_mask;
        full = ((mem << 1) | int'(din)) & reg_mask;
        // newest bit sits at bit 0 of full and meets the top tap of the polynomial
        for (j = 0; j < n; j++) begin
            pv = poly_at(j);
            par = 1'b0;
            for (i = 0; i < k; i++)
                par ^= full[i] & pv[k - 1 - i];
            r.coded[j] = par;
        end
        mem = full & mem_mask;

        if (zero_tail) begin
            if (pos >= last) begin
                r.frame_end = 1'b1;
                mem = 0;
                pos = 0;
            end else begin
                pos = pos + 1;
            end
        end else begin
            pos = 0;
        end
        shift_mem = mem[12:0];
        frame_pos = pos[16:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            k_reg     = RST_CONSTRAINT_LENGTH;
            n_reg     = RST_OUTPUTS_PER_BIT;
            taps_lo   = RST_TAPS_GROUP_LOW;
            taps_hi   = RST_TAPS_GROUP_HIGH;
            zero_tail = RST_ZERO_TAIL_MODE;
            info_len  = RST_INFO_LENGTH;
            shift_mem = '0;
            frame_pos = '0;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result with no request waiting: coded_bits %0h", m_coded_bits);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    if (want.frame_end) ends_seen++;
                    if (want.status == STATUS_TAIL_NONZERO) tails_seen++;
                    if (want.status == STATUS_BAD_CONFIG) bads_seen++;
                    if (m_coded_bits !== want.coded) begin
                        $error("coded_bits expected %0h actual %0h", want.coded, m_coded_bits);
                        errors++;
                    end
                    if (m_frame_end !== want.frame_end) begin
                        $error("frame_end expected %0b actual %0b",
                               want.frame_end, m_frame_end);
                        errors++;
                    end
                    if (m_status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, m_status);
                        errors++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_CONSTRAINT_LENGTH: k_reg     = cfg_wr_data[K_W-1:0];
                    CFG_OUTPUTS_PER_BIT:   n_reg     = cfg_wr_data[N_W-1:0];
                    CFG_TAPS_GROUP_LOW:    taps_lo   = cfg_wr_data;
                    CFG_TAPS_GROUP_HIGH:   taps_hi   = cfg_wr_data;
                    CFG_ZERO_TAIL_MODE:    zero_tail = cfg_wr_data[0];
                    CFG_INFO_LENGTH:       info_len  = cfg_wr_data[INFO_LEN_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                fresh = encode_bit(s_info_bit);
                expected_q.insert(expected_q.size(), fresh);
            end
        end
        mismatches   <= errors;
        outstanding  <= expected_q.size();
        bits_checked <= checked;
        frame_ends   <= ends_seen;
        tail_flags   <= tails_seen;
        bad_configs  <= bads_seen;
    end

endmodule

FILE: tb/sv/convolutional_encoder_rate_1_n_core_test.sv
`timescale 1ns / 1ps

// Top of the encoder testbench: drives configuration, information bits and
// receiver back-pressure, and gives the verdict from the checker's counts.
module convolutional_encoder_rate_1_n_core_test;
    import cenc_pkg::*;

    // Kinds of polynomial set handed to the encoder.
    localparam int TAPS_CLEAN   = 0;  // every active polynomial valid
    localparam int TAPS_NO_TOP  = 1;  // one active polynomial misses its top tap
    localparam int TAPS_ABOVE_K = 2;  // one active polynomial taps beyond K (misses its top tap when K is 14)

    localparam int HOLD_OFF_CYCLES = 80;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    wire                   s_ready;
    logic                  s_info_bit  = 1'b0;
    wire                   m_valid;
    logic                  m_ready     = 1'b0;
    wire [CODED_W-1:0]     m_coded_bits;
    wire                   m_frame_end;
    wire [STATUS_W-1:0]    m_status;

    int mismatches, outstanding, bits_checked, frame_ends, tail_flags, bad_configs;

    // Shared between the request side and the receiver.
    bit calm          = 1'b0;  // no idling on either side
    bit hold_off_req  = 1'b0;  // ask the receiver for one long stall

    // Request-side view of the frame, so tail bits can be shaped.
    int cur_len       = 88;
    int cur_k         = 7;
    int cur_last      = 93;
    bit cur_zt        = 1'b0;
    bit cur_bad       = 1'b0;
    int tx_pos        = 0;
    int settings_used = 1;

    always #4 aclk = ~aclk;

    convolutional_encoder_rate_1_n_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_info_bit   (s_info_bit),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_coded_bits (m_coded_bits),
        .m_frame_end  (m_frame_end),
        .m_status     (m_status)
    );

    cenc_result_checker u_result_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_info_bit   (s_info_bit),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_coded_bits (m_coded_bits),
        .m_frame_end  (m_frame_end),
        .m_status     (m_status),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .bits_checked (bits_checked),
        .frame_ends   (frame_ends),
        .tail_flags   (tail_flags),
        .bad_configs  (bad_configs)
    );

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off on request, none when calm.
    initial begin
        forever begin
            if (hold_off_req) begin
                // hold m_ready low long enough for the encoder to back up
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Build a 112-bit polynomial set, polynomial j at bit 14j. Active slots get
    // valid polynomials of length k unless a flaw is asked for; idle slots get junk.
    function automatic logic [2*CFG_DATA_W-1:0] random_taps(int k, int n, int flaw);
        logic [2*CFG_DATA_W-1:0] t;
        logic [POLY_FIELD-1:0]   p;
        int j, victim;
        t = '0;
        victim = $urandom_range(0, n - 1);
        for (j = 0; j < 8; j++) begin
            if (j < n) begin
                p = POLY_FIELD'($urandom) & POLY_FIELD'((1 << k) - 1);
                p[k-1] = 1'b1;
                if (j == victim && flaw == TAPS_NO_TOP) p[k-1] = 1'b0;
                if (j == victim && flaw == TAPS_ABOVE_K) begin
                    if (k < 14) p[$urandom_range(k, 13)] = 1'b1;
                    else p[k-1] = 1'b0;
                end
            end else begin
                p = ($urandom_range(0, 3) == 0) ? '1 : POLY_FIELD'($urandom);
            end
            t[POLY_FIELD*j +: POLY_FIELD] = p;
        end
        return t;
    endfunction

    function automatic int clamp_k(int raw_k);
        return (raw_k < K_MIN) ? K_MIN : (raw_k > 14) ? 14 : raw_k;
    endfunction

    function automatic int clamp_n(int raw_n);
        return (raw_n < 2 || raw_n > 8) ? N_DEFAULT : raw_n;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    // Write all six registers back to back; the encoder is idle here.
    task automatic apply_setting(int raw_k, int raw_n, logic [2*CFG_DATA_W-1:0] taps,
                                 bit zt, int len, int flaw);
        write_reg(CFG_CONSTRAINT_LENGTH, CFG_DATA_W'(raw_k));
        write_reg(CFG_OUTPUTS_PER_BIT,   CFG_DATA_W'(raw_n));
        write_reg(CFG_TAPS_GROUP_LOW,    taps[CFG_DATA_W-1:0]);
        write_reg(CFG_TAPS_GROUP_HIGH,   taps[2*CFG_DATA_W-1:CFG_DATA_W]);
        write_reg(CFG_ZERO_TAIL_MODE,    CFG_DATA_W'(zt));
        write_reg(CFG_INFO_LENGTH,       CFG_DATA_W'(len));
        cfg_wr_en <= 1'b0;
        cur_k    = clamp_k(raw_k);
        cur_len  = (len == 0) ? 1 : len;
        cur_last = cur_len + cur_k - 2;
        cur_zt   = zt;
        cur_bad  = (flaw != TAPS_CLEAN);
        settings_used++;
    endtask

    // Drop valid and wait until every expected result has been taken.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Offer one bit, with an optional idle burst first, and track the frame.
    task automatic offer_bit(logic b);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid    <= 1'b0;
            s_info_bit <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_info_bit <= b;
        do @(posedge aclk); while (!s_ready);
        // a bad polynomial set leaves the frame where it was
        if (!cur_bad) begin
            if (!cur_zt) tx_pos = 0;
            else if (tx_pos >= cur_last) tx_pos = 0;
            else tx_pos++;
        end
    endtask

    initial begin
        int i, count, target, raw_k, raw_n, len, flaw;
        bit zt, b;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset configuration, continuous stream.
        offer_bit(1'b1); offer_bit(1'b1); offer_bit(1'b0);
        offer_bit(1'b1); offer_bit(1'b0); offer_bit(1'b0);

        // Shortest memory, widest output, zero info length taken as one bit:
        // frames of three bits, the first one with flagged tail bits.
        drain_results();
        apply_setting(3, 8, random_taps(3, 8, TAPS_CLEAN), 1'b1, 0, TAPS_CLEAN);
        offer_bit(1'b1); offer_bit(1'b1); offer_bit(1'b1);
        offer_bit(1'b1); offer_bit(1'b0); offer_bit(1'b0);

        // K above range clamps to 14, n above range falls back to two; stop
        // in the first tail bit, then shrink K so the frame is already at its last bit.
        drain_results();
        apply_setting(15, 15, random_taps(14, 2, TAPS_CLEAN), 1'b1, 2, TAPS_CLEAN);
        offer_bit(1'b1); offer_bit(1'b1); offer_bit(1'b1);
        drain_results();
        apply_setting(2, 2, random_taps(3, 2, TAPS_CLEAN), 1'b1, 2, TAPS_CLEAN);
        offer_bit(1'b1); offer_bit(1'b1);

        // Bad polynomial sets: missing top tap, then a tap beyond K.
        drain_results();
        apply_setting(5, 4, random_taps(5, 4, TAPS_NO_TOP), 1'b0, 7, TAPS_NO_TOP);
        offer_bit(1'b1); offer_bit(1'b0); offer_bit(1'b1);
        drain_results();
        apply_setting(5, 4, random_taps(5, 4, TAPS_ABOVE_K), 1'b0, 7, TAPS_ABOVE_K);
        offer_bit(1'b1); offer_bit(1'b0);

        // Random settings; the first two pin the extremes of K and n.
        for (i = 0; i < 8; i++) begin
            drain_results();
            raw_k = $urandom_range(3, 14);
            raw_n = $urandom_range(2, 8);
            if ($urandom_range(0, 7) == 0) raw_k = ($urandom_range(0, 1) == 0) ?
                                                   $urandom_range(0, 2) : 15;
            if ($urandom_range(0, 7) == 0) raw_n = ($urandom_range(0, 1) == 0) ?
                                                   $urandom_range(0, 1) : $urandom_range(9, 15);
            zt  = 1'($urandom_range(0, 1));
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 24);
            if ($urandom_range(0, 9) == 0) len = 0;
            flaw = TAPS_CLEAN;
            if (i >= 4 && i < 7 && $urandom_range(0, 5) == 0)
                flaw = $urandom_range(TAPS_NO_TOP, TAPS_ABOVE_K);
            case (i)
                0: begin raw_k = 14; raw_n = 8; zt = 1'b1; end
                1: begin raw_k = 3;  raw_n = 2; zt = 1'b0; end
                2: begin zt = 1'b1; len = 16'hFFFF; end
                default: ;
            endcase
            calm = (i == 4 || i == 7);
            apply_setting(raw_k, raw_n, random_taps(clamp_k(raw_k), clamp_n(raw_n), flaw),
                          zt, len, flaw);
            // back up the encoder while requests keep coming
            if (i == 3) hold_off_req = 1'b1;
            target = (flaw != TAPS_CLEAN) ? 16 : 110;
            count = 0;
            // finish the current frame unless frames are too long to bother
            while (count < target ||
                   (cur_zt && !cur_bad && tx_pos != 0 && cur_last < 200)) begin
                if (cur_zt && tx_pos >= cur_len) b = ($urandom_range(0, 9) == 0);
                else b = 1'($urandom_range(0, 1));
                offer_bit(b);
                count++;
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);

        $display("Encoded %0d bits under %0d register settings.", bits_checked, settings_used);
        $display("Saw %0d frame ends, %0d flagged tail bits, %0d bad-polynomial results.",
                 frame_ends, tail_flags, bad_configs);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
